FILE: rtl/iecf_pkg.sv
// Package for the input event change filter: event kind codes and field types.
// No dependencies; used by the filter top level and its port checker.
`timescale 1ns / 1ps

package iecf_pkg;

   // event kind as carried on both channels
   typedef logic [2:0] kind_type;

   localparam kind_type KIND_TILT    = 3'd0;
   localparam kind_type KIND_TRIGGER = 3'd1;
   localparam kind_type KIND_DOWN    = 3'd2;
   localparam kind_type KIND_UP      = 3'd3;
   localparam kind_type KIND_OTHER   = 3'd4;
   localparam kind_type KIND_LOST    = 3'd5;

   // fixed field widths of the event item
   localparam int DEVICE_W = 4;
   localparam int AXIS_W   = 3;
   localparam int BUTTON_W = 6;
   localparam int VALUE_W  = 32;

   typedef logic [DEVICE_W-1:0] device_type;
   typedef logic [AXIS_W-1:0]   axis_type;
   typedef logic [BUTTON_W-1:0] button_type;
   typedef logic [VALUE_W-1:0]  value_type;

endpackage

FILE: rtl/input_event_change_filter.sv
// Input event change filter: drops axis and button events that do not change
// the per-device state, clears a device on device-lost. Uses iecf_pkg.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------
//   req     | in        | req_valid/req_stall  | kind, device, axis, button, value
//   rsp     | out       | rsp_valid/rsp_stall  | out kind, device, axis, button, value
//
// One event per cycle sustained while no result is stalled; a forwarded event is
// offered once it has passed the input register, which captures the event
// together with the registered read of its device row, and the compare/update
// stage, which writes the row back and loads the result register.
// Reset clears the per-device row valid flags at once; a row never written
// reads as zero, so there is no clearing pass.
// A stalled result holds in the output register; the update stage waits only
// when it has a result to pass and that register cannot take it.
`timescale 1ns / 1ps

module input_event_change_filter #(
   parameter int DEVICES = 16,
   parameter int AXES    = 8,
   parameter int BUTTONS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   // event input
   input  logic                 req_valid,
   output logic                 req_stall,
   input  iecf_pkg::kind_type   req_kind,
   input  iecf_pkg::device_type req_device_index,
   input  iecf_pkg::axis_type   req_axis_index,
   input  iecf_pkg::button_type req_button_index,
   input  iecf_pkg::value_type  req_axis_value,
   // forwarded events
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output iecf_pkg::kind_type   rsp_out_kind,
   output iecf_pkg::device_type rsp_out_device,
   output iecf_pkg::axis_type   rsp_out_axis,
   output iecf_pkg::button_type rsp_out_button,
   output iecf_pkg::value_type  rsp_out_value
);

   localparam int DEV_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;
   localparam int AX_W  = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int BT_W  = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

   typedef logic [AXES-1:0][iecf_pkg::VALUE_W-1:0] axis_row_type;
   typedef logic [BUTTONS-1:0]                     button_row_type;

   // device row store
   axis_row_type   axis_mem [DEVICES];
   button_row_type button_mem [DEVICES];
   logic [DEVICES-1:0] row_valid_ff;

   // update stage
   logic                 s1_valid_ff, s1_valid_in;
   iecf_pkg::kind_type   s1_kind_ff;
   iecf_pkg::device_type s1_dev_ff;
   logic [DEV_W-1:0]     s1_row_ff;
   iecf_pkg::axis_type   s1_axis_ff;
   iecf_pkg::button_type s1_button_ff;
   iecf_pkg::value_type  s1_value_ff;
   logic                 s1_dev_ok_ff, s1_axis_ok_ff, s1_btn_ok_ff;
   axis_row_type         rd_axes_ff;
   button_row_type       rd_buttons_ff;
   logic                 rd_valid_ff;
   logic                 fwd_hit_ff, fwd_hit_in;
   axis_row_type         fwd_axes_ff;
   button_row_type       fwd_buttons_ff;

   // output register
   logic                 out_valid_ff, out_valid_in;
   iecf_pkg::kind_type   out_kind_ff;
   iecf_pkg::device_type out_dev_ff;
   iecf_pkg::axis_type   out_axis_ff;
   iecf_pkg::button_type out_button_ff;
   iecf_pkg::value_type  out_value_ff;

   logic             req_xfer, rsp_xfer, out_ready, s1_go;
   logic             req_dev_ok;
   logic [DEV_W-1:0] req_row;
   axis_row_type     cur_axes, new_axes;
   button_row_type   cur_buttons, new_buttons;
   logic             s1_emit, s1_wr;

   // input decode: range checks and store row
   assign req_dev_ok = ({5'd0, req_device_index} < 9'(DEVICES));
   assign req_row    = req_dev_ok ? DEV_W'(req_device_index) : '0;

   // handshake
   assign out_ready = !out_valid_ff || !rsp_stall;
   assign s1_go     = s1_valid_ff && (!s1_emit || out_ready);
   assign req_stall = s1_valid_ff && !s1_go;
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = out_valid_ff && !rsp_stall;

   // compare and update of the addressed row
   always_comb begin
      logic [AX_W-1:0] ax;
      logic [BT_W-1:0] bt;
      logic            pressed;
      ax = AX_W'(s1_axis_ff);
      bt = BT_W'(s1_button_ff);
      if (fwd_hit_ff) begin
         cur_axes    = fwd_axes_ff;
         cur_buttons = fwd_buttons_ff;
      end else if (rd_valid_ff) begin
         cur_axes    = rd_axes_ff;
         cur_buttons = rd_buttons_ff;
      end else begin
         cur_axes    = '0;
         cur_buttons = '0;
      end
      new_axes    = cur_axes;
      new_buttons = cur_buttons;
      pressed     = cur_buttons[bt];
      s1_emit     = 1'b0;
      s1_wr       = 1'b0;
      case (s1_kind_ff)
         iecf_pkg::KIND_TILT, iecf_pkg::KIND_TRIGGER: begin
            if (s1_axis_ok_ff && (cur_axes[ax] != s1_value_ff)) begin
               new_axes[ax] = s1_value_ff;
               s1_emit      = 1'b1;
               s1_wr        = 1'b1;
            end
         end
         iecf_pkg::KIND_DOWN: begin
            if (s1_btn_ok_ff && !pressed) begin
               new_buttons[bt] = 1'b1;
               s1_emit         = 1'b1;
               s1_wr           = 1'b1;
            end
         end
         iecf_pkg::KIND_UP: begin
            if (s1_btn_ok_ff && pressed) begin
               new_buttons[bt] = 1'b0;
               s1_emit         = 1'b1;
               s1_wr           = 1'b1;
            end
         end
         iecf_pkg::KIND_LOST: begin
            new_axes    = '0;
            new_buttons = '0;
            s1_emit     = 1'b1;
            s1_wr       = s1_dev_ok_ff;
         end
         default: begin
            s1_emit = 1'b1;
         end
      endcase
   end

   // next-state of the control flags
   assign s1_valid_in  = req_xfer || (s1_valid_ff && !s1_go);
   assign out_valid_in = (s1_go && s1_emit) || (out_valid_ff && !rsp_xfer);
   // a row written back on the same edge as a new read of that row is bypassed
   assign fwd_hit_in   = s1_go && s1_wr && (s1_row_ff == req_row);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         row_valid_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (req_xfer) begin
            fwd_hit_ff <= fwd_hit_in;
         end
         if (s1_go && s1_wr) begin
            row_valid_ff[s1_row_ff] <= 1'b1;
         end
      end
   end

   // row store write-back and registered read
   always_ff @(posedge clock) begin
      if (s1_go && s1_wr) begin
         axis_mem[s1_row_ff]   <= new_axes;
         button_mem[s1_row_ff] <= new_buttons;
      end
      if (req_xfer) begin
         rd_axes_ff    <= axis_mem[req_row];
         rd_buttons_ff <= button_mem[req_row];
      end
   end

   // update stage payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_kind_ff     <= req_kind;
         s1_dev_ff      <= req_device_index;
         s1_row_ff      <= req_row;
         s1_axis_ff     <= req_axis_index;
         s1_button_ff   <= req_button_index;
         s1_value_ff    <= req_axis_value;
         s1_dev_ok_ff   <= req_dev_ok;
         s1_axis_ok_ff  <= ({4'd0, req_axis_index} < 7'(AXES));
         s1_btn_ok_ff   <= ({1'b0, req_button_index} < 7'(BUTTONS));
         rd_valid_ff    <= row_valid_ff[req_row];
         fwd_axes_ff    <= new_axes;
         fwd_buttons_ff <= new_buttons;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (s1_go && s1_emit) begin
         out_kind_ff <= s1_kind_ff;
         out_dev_ff  <= s1_dev_ff;
         case (s1_kind_ff)
            iecf_pkg::KIND_TILT, iecf_pkg::KIND_TRIGGER: begin
               out_axis_ff   <= s1_axis_ff;
               out_button_ff <= '0;
               out_value_ff  <= s1_value_ff;
            end
            iecf_pkg::KIND_DOWN, iecf_pkg::KIND_UP: begin
               out_axis_ff   <= '0;
               out_button_ff <= s1_button_ff;
               out_value_ff  <= '0;
            end
            default: begin
               out_axis_ff   <= '0;
               out_button_ff <= '0;
               out_value_ff  <= '0;
            end
         endcase
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_kind   = out_kind_ff;
   assign rsp_out_device = out_dev_ff;
   assign rsp_out_axis   = out_axis_ff;
   assign rsp_out_button = out_button_ff;
   assign rsp_out_value  = out_value_ff;

endmodule

FILE: rtl/iecf_checker.sv
// Port checker for the input event change filter, bound to the top level.
// Depends on iecf_pkg for the kind codes.
`timescale 1ns / 1ps

module iecf_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input iecf_pkg::kind_type   rsp_out_kind,
   input iecf_pkg::axis_type   rsp_out_axis,
   input iecf_pkg::button_type rsp_out_button,
   input iecf_pkg::value_type  rsp_out_value
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // nothing is offered right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // the input only waits behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without a stalled result");

   // axis fields are zero on anything but an axis event
   a_axis_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_kind != iecf_pkg::KIND_TILT)
         && (rsp_out_kind != iecf_pkg::KIND_TRIGGER)
      |-> (rsp_out_axis == '0) && (rsp_out_value == '0))
      else $error("axis fields set on a non-axis event");

   // button field is zero on anything but a button event
   a_button_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_kind != iecf_pkg::KIND_DOWN)
         && (rsp_out_kind != iecf_pkg::KIND_UP)
      |-> (rsp_out_button == '0))
      else $error("button field set on a non-button event");

endmodule

bind input_event_change_filter iecf_checker u_iecf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_out_kind   (rsp_out_kind),
   .rsp_out_axis   (rsp_out_axis),
   .rsp_out_button (rsp_out_button),
   .rsp_out_value  (rsp_out_value)
);
